@@ rtl/core/iwo_pkg.sv @@
package iwo_pkg;

  // Item and register field widths
  localparam int OP_W       = 1;
  localparam int INDEX_W    = 7;
  localparam int VALUE_W    = 16;
  localparam int INC_W      = 23;
  localparam int GAIN_W     = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 23;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK  = 1'b0;
  localparam logic [OP_W-1:0] OP_WRITE = 1'b1;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_INC = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_AMP_GAIN  = 1'b1;

  // Register reset values
  localparam logic [INC_W-1:0]  PHASE_INC_RESET = 23'd83697;
  localparam logic [GAIN_W-1:0] AMP_GAIN_RESET  = 16'd16384;

  typedef enum logic [2:0] {
    OSC_IDLE,
    OSC_LERP,
    OSC_ROUND,
    OSC_SCALE,
    OSC_EMIT
  } osc_state_t;

endpackage

@@ rtl/core/interpolating_wavetable_oscillator.sv @@
// Channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------
// config   | cfg_we                    | cfg_index, cfg_wdata
// input    | in_valid / in_stall       | operation, entry_index, entry_value
// output   | out_valid / out_stall     | sample
//
// A write item is taken without busying the block. A tick item occupies
// the block through four stages behind the table read (lerp multiply,
// round, gain multiply, saturate) and, alongside, the phase reduction unit;
// the input stays stalled until both are done.
// Reset (rst, synchronous) clears the phase, the control state and the
// registers to their defaults; the table holds garbage until written.
// A stalled output holds its item; the block still takes writes and one more
// tick, which then waits in the last stage and stalls the input until the
// output moves.
module interpolating_wavetable_oscillator #(
  parameter int TABLE_DEPTH   = 128,
  parameter int FRACTION_BITS = 16,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [iwo_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [iwo_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [iwo_pkg::OP_W-1:0]               operation,
  input  logic [iwo_pkg::INDEX_W-1:0]            entry_index,
  input  logic signed [iwo_pkg::VALUE_W-1:0]     entry_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [SAMPLE_BITS-1:0]          sample
);
  import iwo_pkg::*;

  // Table address and phase widths
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = AW + FRACTION_BITS;
  // Phase register is wide enough to hold phase + increment before reduction
  localparam int RW = ((PW > INC_W) ? PW : INC_W) + 1;
  localparam logic [RW-1:0] PHASE_MOD = RW'(TABLE_DEPTH) << FRACTION_BITS;
  localparam logic [RW-1:0] MAX_SUM   = PHASE_MOD + RW'((longint'(1) << INC_W) - 2);

  // Number of extra restoring steps so that PHASE_MOD << (STEPS + 1) exceeds
  // the largest unreduced sum
  function automatic int red_steps();
    int k;
    k = 0;
    for (int j = 0; j < RW; j++) begin
      if ((longint'(PHASE_MOD) << (k + 1)) <= longint'(MAX_SUM)) begin
        k = k + 1;
      end
    end
    return k;
  endfunction

  localparam int STEPS = red_steps();
  localparam int CNT_W = (STEPS > 0) ? $clog2(STEPS + 1) : 1;
  localparam logic [RW-1:0] DIV_INIT = PHASE_MOD << STEPS;

  // Datapath widths
  localparam int DIFF_W = VALUE_W + 1;
  localparam int ACC_W  = FRACTION_BITS + DIFF_W + 1;
  localparam int GP_W   = DIFF_W + GAIN_W + 1;
  localparam logic signed [ACC_W-1:0] LERP_HALF =
    ACC_W'(longint'(1) << (FRACTION_BITS - 1));
  localparam logic signed [GP_W-1:0] GAIN_HALF = GP_W'(longint'(1) << 14);
  localparam logic signed [GP_W-1:0] S_MAX =
    GP_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [GP_W-1:0] S_MIN = -S_MAX - GP_W'(1);

  // Configuration registers
  logic [INC_W-1:0]  phase_inc;
  logic [GAIN_W-1:0] amp_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_inc <= PHASE_INC_RESET;
      amp_gain  <= AMP_GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_INC: phase_inc <= cfg_wdata[INC_W-1:0];
        REG_AMP_GAIN:  amp_gain  <= cfg_wdata[GAIN_W-1:0];
        default:       ;
      endcase
    end
  end

  // Control
  osc_state_t state, state_next;
  logic       red_active;
  logic       tick_acc;
  logic       wr_en;
  logic       out_load;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      OSC_IDLE:  if (in_acc && operation == OP_TICK) state_next = OSC_LERP;
      OSC_LERP:  state_next = OSC_ROUND;
      OSC_ROUND: state_next = OSC_SCALE;
      OSC_SCALE: state_next = OSC_EMIT;
      OSC_EMIT:  if (!out_valid || !out_stall) state_next = OSC_IDLE;
      default:   state_next = OSC_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != OSC_IDLE) || red_active;
    tick_acc = in_acc && (operation == OP_TICK);
    wr_en    = in_acc && (operation == OP_WRITE) && (int'(entry_index) < TABLE_DEPTH);
    out_load = (state == OSC_EMIT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= OSC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Phase accumulator with restoring modulo reduction, one step a cycle
  logic [RW-1:0]    phase;
  logic [RW-1:0]    red_div;
  logic [CNT_W-1:0] red_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      red_active <= 1'b0;
      red_div    <= '0;
      red_cnt    <= '0;
    end else if (tick_acc) begin
      phase      <= phase + RW'(phase_inc);
      red_div    <= DIV_INIT;
      red_cnt    <= CNT_W'(STEPS);
      red_active <= 1'b1;
    end else if (red_active) begin
      if (phase >= red_div) begin
        phase <= phase - red_div;
      end
      red_div <= red_div >> 1;
      if (red_cnt == '0) begin
        red_active <= 1'b0;
      end else begin
        red_cnt <= red_cnt - CNT_W'(1);
      end
    end
  end

  // Wave table: one write port, two registered read ports
  logic signed [VALUE_W-1:0] wave_mem [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] rd0, rd1;
  logic [AW-1:0]             idx0, idx1;
  logic [FRACTION_BITS-1:0]  frac_q;

  assign idx0 = phase[PW-1:FRACTION_BITS];
  assign idx1 = (idx0 == AW'(TABLE_DEPTH - 1)) ? '0 : idx0 + AW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wave_mem[AW'(entry_index)] <= entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      rd0    <= wave_mem[idx0];
      rd1    <= wave_mem[idx1];
      frac_q <= phase[FRACTION_BITS-1:0];
    end
  end

  // Interpolate: v0 + (v1 - v0) * frac, rounded to nearest with ties up
  logic signed [DIFF_W-1:0] diff;
  logic signed [ACC_W-1:0]  lerp_prod;
  logic signed [VALUE_W-1:0] v0_q;
  logic signed [ACC_W-1:0]  lerp_acc;
  logic signed [ACC_W-1:0]  lerp_rnd;
  logic signed [DIFF_W-1:0] interp;
  logic signed [GP_W-1:0]   gain_prod;
  logic signed [GP_W-1:0]   scaled;
  logic signed [GP_W-1:0]   clipped;

  assign diff     = DIFF_W'(rd1) - DIFF_W'(rd0);
  assign lerp_acc = (ACC_W'(v0_q) <<< FRACTION_BITS) + lerp_prod;
  assign lerp_rnd = (lerp_acc + LERP_HALF) >>> FRACTION_BITS;
  assign scaled   = (gain_prod + GAIN_HALF) >>> 15;

  always_comb begin
    if (scaled > S_MAX) begin
      clipped = S_MAX;
    end else if (scaled < S_MIN) begin
      clipped = S_MIN;
    end else begin
      clipped = scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (state == OSC_LERP) begin
      lerp_prod <= ACC_W'(diff) * ACC_W'($signed({1'b0, frac_q}));
      v0_q      <= rd0;
    end
    if (state == OSC_ROUND) begin
      interp <= lerp_rnd[DIFF_W-1:0];
    end
    if (state == OSC_SCALE) begin
      gain_prod <= GP_W'(interp) * GP_W'($signed({1'b0, amp_gain}));
    end
  end

  // Output register: hold the item while the far side stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample <= clipped[SAMPLE_BITS-1:0];
    end
  end

endmodule

@@ sim/tb_interpolating_wavetable_oscillator.sv @@
`timescale 1ns / 100ps

module tb_interpolating_wavetable_oscillator;
  import iwo_pkg::*;

  // Fixed point layout of the phase: 7 index bits above 16 fraction bits
  localparam int FRAC_BITS = 16;
  localparam int SAMPLE_W = 16;
  localparam longint SAT_HI = 32767;
  localparam longint SAT_LO = -32768;
  // Margin for the pipeline to empty once every owed sample is out
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int ITEMS_PER_SETTING = 174;
  localparam int RANDOM_SETTINGS = 7;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [OP_W-1:0] operation;
  logic [INDEX_W-1:0] entry_index;
  logic signed [VALUE_W-1:0] entry_value;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;

  // Own copy of the oscillator state, advanced as each item is accepted
  logic signed [VALUE_W-1:0] wave_mem [0:(1 << INDEX_W)-1];
  logic [INC_W-1:0] osc_phase;
  logic [INC_W-1:0] inc_reg;
  logic [GAIN_W-1:0] gain_reg;

  // Samples still owed by the block, oldest first
  logic signed [SAMPLE_W-1:0] sample_due [$];
  logic signed [SAMPLE_W-1:0] due_now;

  // Idling controls shared between the stimulus and the sink
  bit gap_en;
  bit stall_en;
  bit hold_off_req = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  int fails = 0;
  int n_ticks = 0;
  int n_writes = 0;
  int n_checked = 0;
  int n_settings = 0;

  interpolating_wavetable_oscillator i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample      (sample)
  );

  always #4 clk = ~clk;

  // Idle length: mostly from the lower range, now and then a long stretch
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Table word with the two extremes turning up often
  function automatic logic signed [VALUE_W-1:0] random_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh7fff;
    return VALUE_W'($urandom);
  endfunction

  // Sample for the current phase: lerp between the entry at the integer
  // phase and the one after it (wrapping to entry 0), round to nearest with
  // ties up, scale by the Q1.15 gain with the same rounding, then saturate.
  function automatic logic signed [SAMPLE_W-1:0] tick_sample();
    logic [INDEX_W-1:0] i0, i1;
    longint v0, v1, frac, acc, lerp, scaled;
    i0 = osc_phase[INC_W-1:FRAC_BITS];
    i1 = i0 + INDEX_W'(1);
    v0 = longint'(wave_mem[i0]);
    v1 = longint'(wave_mem[i1]);
    frac = longint'(osc_phase[FRAC_BITS-1:0]);
    acc = (v0 <<< FRAC_BITS) + (v1 - v0) * frac;
    lerp = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    scaled = (lerp * longint'(gain_reg) + 64'sd16384) >>> 15;
    if (scaled > SAT_HI) scaled = SAT_HI;
    else if (scaled < SAT_LO) scaled = SAT_LO;
    return scaled[SAMPLE_W-1:0];
  endfunction

  // Offer one item at a falling edge and hold it until the block takes it.
  // Valid stays high on return, so a following item with no gap goes out
  // back to back without valid dropping in between.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                           input logic signed [VALUE_W-1:0] val);
    int gap;
    gap = (gap_en && $urandom_range(0, 99) >= 55) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    entry_index <= idx;
    entry_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Accepted at this edge: advance the prediction
    if (op == OP_WRITE) begin
      wave_mem[idx] = val;
      n_writes++;
    end else begin
      sample_due.push_back(tick_sample());
      osc_phase = osc_phase + inc_reg;
      n_ticks++;
    end
    @(negedge clk);
  endtask

  // Ticks carry random junk in the unused fields
  task automatic tick();
    send_item(OP_TICK, INDEX_W'($urandom), VALUE_W'($urandom));
  endtask

  // Drop valid, wait for every owed sample, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sample_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Registers only change with the block idle
  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == REG_PHASE_INC) inc_reg = data[INC_W-1:0];
    else gain_reg = data[GAIN_W-1:0];
    n_settings++;
  endtask

  // Land the phase on a chosen value: step there with one tick
  task automatic seek_phase(input logic [INC_W-1:0] target);
    logic [INC_W-1:0] step;
    step = target - osc_phase;
    set_reg(REG_PHASE_INC, step);
    tick();
  endtask

  // Fill every entry first so that no tick ever reads an unwritten word
  task automatic test_table_load();
    for (int i = 0; i < (1 << INDEX_W); i++)
      send_item(OP_WRITE, INDEX_W'(i), random_word());
  endtask

  // Ticks from reset: phase zero, default increment and half gain
  task automatic test_reset_defaults();
    repeat (3) tick();
  endtask

  // Extremes of the table words and of both registers, the wrap from the
  // last entry back to entry 0, saturation both ways and a rounding tie
  task automatic test_directed_extremes();
    send_item(OP_WRITE, 7'd0, 16'sh7fff);
    send_item(OP_WRITE, 7'd127, 16'sh8000);
    send_item(OP_WRITE, 7'd1, 16'sh8000);
    send_item(OP_WRITE, 7'd126, 16'sh7fff);
    // Gain far above one: drive the output into both rails
    set_reg(REG_AMP_GAIN, CFG_DATA_W'(16'hffff));
    seek_phase('0);
    // Step backwards by one LSB: phase wraps below zero into the last entry
    set_reg(REG_PHASE_INC, '1);
    tick();
    tick();
    seek_phase(INC_W'(127) << FRAC_BITS);
    tick();
    set_reg(REG_AMP_GAIN, '0);
    tick();
    // Unity gain, halfway between a full-scale pair: the lerp lands on a tie
    set_reg(REG_AMP_GAIN, CFG_DATA_W'(16'h8000));
    seek_phase(INC_W'(16'h8000));
    set_reg(REG_PHASE_INC, CFG_DATA_W'(1) << FRAC_BITS);
    tick();
    tick();
  endtask

  // Hold the sink off for a long stretch while ticks keep coming, so that
  // the block fills and stalls its input; then pause until all have drained
  task automatic test_backpressure();
    gap_en = 1'b0;
    hold_off_req = 1'b1;
    repeat (40) tick();
    settle();
    gap_en = 1'b1;
  endtask

  // Long runs of mixed ticks and writes under several register settings,
  // one stretch with no idling on either side
  task automatic test_random_stream();
    logic [INC_W-1:0] inc;
    logic [GAIN_W-1:0] gain;
    for (int p = 0; p < RANDOM_SETTINGS; p++) begin
      case (p)
        0: inc = '0;
        1: inc = '1;
        default: begin
          case ($urandom_range(0, 4))
            0: inc = INC_W'($urandom_range(1, 4095));
            1: inc = INC_W'($urandom);
            2: inc = INC_W'($urandom_range(1, 127)) << FRAC_BITS;
            3: inc = INC_W'($urandom_range(1, 3 << FRAC_BITS));
            default: inc = PHASE_INC_RESET;
          endcase
        end
      endcase
      case (p)
        0: gain = 16'h8000;
        1: gain = 16'hffff;
        default: begin
          case ($urandom_range(0, 3))
            0: gain = GAIN_W'($urandom);
            1: gain = GAIN_W'($urandom_range(0, 32768));
            2: gain = AMP_GAIN_RESET;
            default: gain = GAIN_W'($urandom_range(30000, 32768));
          endcase
        end
      endcase
      set_reg(REG_PHASE_INC, inc);
      set_reg(REG_AMP_GAIN, CFG_DATA_W'(gain));
      gap_en = (p != 3);
      stall_en = (p != 3);
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        if ($urandom_range(0, 99) < 80) tick();
        else send_item(OP_WRITE, INDEX_W'($urandom), random_word());
      end
    end
    gap_en = 1'b1;
    stall_en = 1'b1;
  endtask

  // Sink stall, driven at the falling edge: a requested long hold-off takes
  // priority, otherwise random bursts of stall when enabled
  always @(negedge clk) begin
    if (hold_off_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_en && $urandom_range(0, 99) < 30) begin
      stall_left = idle_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted sample with the oldest one owed
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (sample_due.size() == 0) begin
        $error("sample: none expected, got %0d", sample);
        fails++;
      end else begin
        due_now = sample_due.pop_front();
        n_checked++;
        if (sample !== due_now) begin
          $error("sample mismatch: expected %0d, got %0d", due_now, sample);
          fails++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_TICK;
    entry_index = '0;
    entry_value = '0;
    cfg_we = 1'b0;
    cfg_index = REG_PHASE_INC;
    cfg_wdata = '0;
    osc_phase = '0;
    inc_reg = PHASE_INC_RESET;
    gain_reg = AMP_GAIN_RESET;
    gap_en = 1'b1;
    stall_en = 1'b1;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_table_load();
    test_reset_defaults();
    test_directed_extremes();
    test_backpressure();
    test_random_stream();

    settle();
    $display("Ran %0d ticks and %0d table writes; %0d samples checked.",
             n_ticks, n_writes, n_checked);
    $display("Register writes: %0d, incl. zero/max increment and zero/unity/max gain.",
             n_settings);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Guard against a hung handshake: well beyond the slowest correct run
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
